[sv/rgb_color_matrix_gamma_defines.svh]
// Assertion macros shared by the checker files of this block.
`ifndef RGB_COLOR_MATRIX_GAMMA_DEFINES_SVH
`define RGB_COLOR_MATRIX_GAMMA_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCMG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCMG_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/rcmg_pkg.sv]
`timescale 1ns / 1ps
package rcmg_pkg;

	// Coefficient format
	localparam int COEF_FRAC_BITS = 20;
	// |coef| < 4, so two integer bits plus sign
	localparam int COEF_W = COEF_FRAC_BITS + 3;
	// coefficient times a 9-bit signed (zero-extended) channel
	localparam int PROD_W = COEF_W + 9;
	// three products, with headroom
	localparam int SUM_W = PROD_W + 2;

	// Command codes
	localparam logic OP_PIXEL    = 1'b0;
	localparam logic OP_TABLE_WR = 1'b1;

	typedef logic [7:0] chan_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [SUM_W-1:0] sum_t;

	// Input transaction
	typedef struct packed {
		logic  opcode;
		chan_t red_in;
		chan_t green_in;
		chan_t blue_in;
		chan_t table_index;
		chan_t table_value;
		logic  end_of_frame;
	} cmd_t;

	// Result transaction
	typedef struct packed {
		chan_t red_out;
		chan_t green_out;
		chan_t blue_out;
		logic  frame_done;
	} res_t;

	// Gamma table write port
	typedef struct packed {
		logic  en;
		chan_t index;
		chan_t value;
	} tbl_wr_t;

	// Gamma table read port, one address per channel
	typedef struct packed {
		logic            en;
		logic [2:0][7:0] index;
	} tbl_rd_t;

	// Coefficient magnitudes (decimal scaled by 1e4) in fixed point, halves away from zero
	localparam longint FIX_ONE = longint'(1) << COEF_FRAC_BITS;
	localparam longint M_RR = (longint'(22583) * FIX_ONE + 5000) / 10000;
	localparam longint M_RG = (longint'(1606) * FIX_ONE + 5000) / 10000;
	localparam longint M_RB = (longint'(6317) * FIX_ONE + 5000) / 10000;
	localparam longint M_GR = (longint'(5501) * FIX_ONE + 5000) / 10000;
	localparam longint M_GG = (longint'(14318) * FIX_ONE + 5000) / 10000;
	localparam longint M_GB = (longint'(653) * FIX_ONE + 5000) / 10000;
	localparam longint M_BR = (longint'(1248) * FIX_ONE + 5000) / 10000;
	localparam longint M_BG = (longint'(5268) * FIX_ONE + 5000) / 10000;
	localparam longint M_BB = (longint'(23735) * FIX_ONE + 5000) / 10000;

	// Rows are output channels, columns are red, green, blue inputs
	localparam coef_t COEF [3][3] = '{
		'{COEF_W'(M_RR), COEF_W'(-M_RG), COEF_W'(-M_RB)},
		'{COEF_W'(-M_GR), COEF_W'(M_GG), COEF_W'(-M_GB)},
		'{COEF_W'(-M_BR), COEF_W'(-M_BG), COEF_W'(M_BB)}
	};

	// Reset contents of the gamma table (sRGB encode), evaluated exactly
	localparam int BIG_W = 320;
	typedef logic [7:0] gamma_rom_t [256];

	function automatic logic [BIG_W-1:0] big_pow(input logic [BIG_W-1:0] base, input int e);
		logic [BIG_W-1:0] acc;
		acc = BIG_W'(1);
		for (int k = 0; k < e; k++) begin
			acc = acc * base;
		end
		return acc;
	endfunction

	// Entry i is the largest n with 269.025*(i/255)^(5/12) >= n + 13.525,
	// compared as 269025^12 * i^5 >= (1000n + 13525)^12 * 255^5
	function automatic gamma_rom_t srgb_table();
		gamma_rom_t t;
		logic [BIG_W-1:0] k12;
		logic [BIG_W-1:0] p255;
		logic [BIG_W-1:0] lhs;
		logic [BIG_W-1:0] rhs;
		logic go;
		int n;
		k12 = big_pow(BIG_W'(269025), 12);
		p255 = big_pow(BIG_W'(255), 5);
		n = 0;
		t[0] = 8'd0;
		for (int i = 1; i < 256; i++) begin
			lhs = k12 * big_pow(BIG_W'(i), 5);
			go = 1'b1;
			// entries are monotonic, so the search resumes from the last one
			for (int s = 0; s < 256; s++) begin
				if (go) begin
					if (n < 255) begin
						rhs = big_pow(BIG_W'(1000 * (n + 1) + 13525), 12) * p255;
						if (lhs >= rhs) begin
							n = n + 1;
						end else begin
							go = 1'b0;
						end
					end else begin
						go = 1'b0;
					end
				end
			end
			t[i] = 8'(n);
		end
		return t;
	endfunction

	localparam gamma_rom_t SRGB_ROM = srgb_table();

endpackage

[sv/rcmg_gamma_ram.sv]
`timescale 1ns / 1ps
// Gamma table: three single-read copies so all channels look up per clock.
// Entries never written read back the sRGB reset contents.
module rcmg_gamma_ram (
	input  logic              clk,
	input  logic              arst_n,
	input  rcmg_pkg::tbl_wr_t wr,
	input  rcmg_pkg::tbl_rd_t rd,
	output logic [2:0][7:0]   rd_data
);

	// One flag per entry, set by the first write
	logic [255:0] ent_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
		end else if (wr.en) begin
			ent_vld_q[wr.index] <= 1'b1;
		end
	end

	for (genvar c = 0; c < 3; c++) begin : g_copy
		logic [7:0] mem [256];
		logic [7:0] dat_q;
		logic [7:0] rom_q;
		logic       hit_q;

		// Every copy takes every write; each serves one channel's read
		always_ff @(posedge clk) begin
			if (wr.en) begin
				mem[wr.index] <= wr.value;
			end
			if (rd.en) begin
				dat_q <= mem[rd.index[c]];
				rom_q <= rcmg_pkg::SRGB_ROM[rd.index[c]];
				hit_q <= ent_vld_q[rd.index[c]];
			end
		end

		assign rd_data[c] = hit_q ? dat_q : rom_q;
	end

endmodule

[sv/rgb_color_matrix_gamma.sv]
`timescale 1ns / 1ps
// Color correction (3x3 matrix, 20 fractional bits) plus gamma table on RGB888 pixels.
// One transaction is taken every clock unless a stalled result backs up; a pixel
// passes through four register stages: input, channel products, row sums, and
// the clamped table read that drives the output. Table-write transactions travel the
// same stages and update the table in order with pixel lookups, producing no result.
// The table comes out of reset holding the sRGB encode curve at once, with no clearing
// pass. A stalled result only holds back stages that are full, so empty stages keep
// taking input.
module rgb_color_matrix_gamma (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  rcmg_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output rcmg_pkg::res_t res,
	input  logic           wr_en,
	input  logic           wr_data
);

	logic bypass_q;

	logic rdy1, rdy2, rdy3, rdy4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic byp_s1, byp_s2, byp_s3;
	rcmg_pkg::cmd_t cmd_s1, cmd_s2, cmd_s3;
	logic eof_s4;

	rcmg_pkg::chan_t rgb_s1 [3];
	rcmg_pkg::chan_t rgb_s3 [3];
	rcmg_pkg::prod_t prod_c [3][3];
	rcmg_pkg::prod_t prod_s2 [3][3];
	rcmg_pkg::sum_t  sum_c [3];
	rcmg_pkg::sum_t  sum_s3 [3];
	rcmg_pkg::chan_t idx_c [3];

	rcmg_pkg::tbl_wr_t tbl_wr;
	rcmg_pkg::tbl_rd_t tbl_rd;
	logic [2:0][7:0]   tbl_data;

	// Per-stage flow control: a stage moves when it is empty or its successor moves
	assign rdy4      = !vld_s4 || res_ready;
	assign rdy3      = !vld_s3 || rdy4;
	assign rdy2      = !vld_s2 || rdy3;
	assign rdy1      = !vld_s1 || rdy2;
	assign cmd_ready = rdy1;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bypass_q <= 1'b0;
			vld_s1   <= 1'b0;
			vld_s2   <= 1'b0;
			vld_s3   <= 1'b0;
			vld_s4   <= 1'b0;
		end else begin
			if (wr_en) begin
				bypass_q <= wr_data;
			end
			if (rdy1) begin
				vld_s1 <= cmd_valid;
			end
			if (rdy2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy3) begin
				vld_s3 <= vld_s2;
			end
			// table writes retire here
			if (rdy4) begin
				vld_s4 <= vld_s3 && (cmd_s3.opcode == rcmg_pkg::OP_PIXEL);
			end
		end
	end

	// Stage 1 -> 2: nine constant multiplies
	assign rgb_s1[0] = cmd_s1.red_in;
	assign rgb_s1[1] = cmd_s1.green_in;
	assign rgb_s1[2] = cmd_s1.blue_in;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < 3; k++) begin
				prod_c[c][k] = rcmg_pkg::PROD_W'(rcmg_pkg::COEF[c][k])
					* rcmg_pkg::PROD_W'($signed({1'b0, rgb_s1[k]}));
			end
		end
	end

	// Stage 2 -> 3: row sums
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			sum_c[c] = rcmg_pkg::SUM_W'(prod_s2[c][0]) + rcmg_pkg::SUM_W'(prod_s2[c][1])
				+ rcmg_pkg::SUM_W'(prod_s2[c][2]);
		end
	end

	// Stage 3 -> 4: clamp to 0..255, drop the fraction, or pass the input in bypass
	assign rgb_s3[0] = cmd_s3.red_in;
	assign rgb_s3[1] = cmd_s3.green_in;
	assign rgb_s3[2] = cmd_s3.blue_in;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			if (byp_s3) begin
				idx_c[c] = rgb_s3[c];
			end else if (sum_s3[c][rcmg_pkg::SUM_W-1]) begin
				idx_c[c] = 8'd0;
			end else if (|sum_s3[c][rcmg_pkg::SUM_W-2:rcmg_pkg::COEF_FRAC_BITS+8]) begin
				idx_c[c] = 8'd255;
			end else begin
				idx_c[c] = sum_s3[c][rcmg_pkg::COEF_FRAC_BITS+7:rcmg_pkg::COEF_FRAC_BITS];
			end
		end
	end

	// Table access happens as the transaction leaves stage 3
	always_comb begin
		tbl_wr.en    = vld_s3 && rdy4 && (cmd_s3.opcode == rcmg_pkg::OP_TABLE_WR);
		tbl_wr.index = cmd_s3.table_index;
		tbl_wr.value = cmd_s3.table_value;
		tbl_rd.en    = vld_s3 && rdy4 && (cmd_s3.opcode == rcmg_pkg::OP_PIXEL);
		for (int c = 0; c < 3; c++) begin
			tbl_rd.index[c] = idx_c[c];
		end
	end

	rcmg_gamma_ram u_gamma (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (tbl_wr),
		.rd      (tbl_rd),
		.rd_data (tbl_data)
	);

	// Pipeline payload
	always_ff @(posedge clk) begin
		if (cmd_valid && rdy1) begin
			cmd_s1 <= cmd;
			byp_s1 <= bypass_q;
		end
		if (vld_s1 && rdy2) begin
			prod_s2 <= prod_c;
			cmd_s2  <= cmd_s1;
			byp_s2  <= byp_s1;
		end
		if (vld_s2 && rdy3) begin
			sum_s3 <= sum_c;
			cmd_s3 <= cmd_s2;
			byp_s3 <= byp_s2;
		end
		if (tbl_rd.en) begin
			eof_s4 <= cmd_s3.end_of_frame;
		end
	end

	// Result
	assign res_valid      = vld_s4;
	assign res.red_out    = tbl_data[0];
	assign res.green_out  = tbl_data[1];
	assign res.blue_out   = tbl_data[2];
	assign res.frame_done = eof_s4;

endmodule

[sv/rcmg_checker.sv]
`timescale 1ns / 1ps
`include "rgb_color_matrix_gamma_defines.svh"
// Port-level checks on the color pipeline
module rcmg_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           cmd_valid,
	input logic           cmd_ready,
	input rcmg_pkg::cmd_t cmd,
	input logic           res_valid,
	input logic           res_ready,
	input rcmg_pkg::res_t res,
	input logic           wr_en,
	input logic           wr_data
);

	// Pixel transactions accepted but whose result is not yet taken
	logic [3:0] pend_q;
	logic       pix_acc;
	logic       res_acc;

	assign pix_acc = cmd_valid && cmd_ready && (cmd.opcode == rcmg_pkg::OP_PIXEL);
	assign res_acc = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 4'd0;
		end else begin
			pend_q <= pend_q + 4'(pix_acc) - 4'(res_acc);
		end
	end

	// A free output means every stage can move
	`RCMG_ASSERT_IMP(a_ready_path, clk, arst_n, res_ready, cmd_ready, "input stalled while output free")

	// A waiting result holds
	`RCMG_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid && $stable(res), "result changed while stalled")

	// No result without a pixel in flight (table writes give none)
	`RCMG_ASSERT_IMP(a_no_orphan, clk, arst_n, res_valid, pend_q != 4'd0, "result without pixel transaction")

	// At most one pixel per stage
	`RCMG_ASSERT_IMP(a_pend_bound, clk, arst_n, 1'b1, pend_q <= 4'd4, "too many pixels in flight")

	// No result straight after a transaction enters an empty pipeline
	`RCMG_ASSERT_NXT(a_min_latency, clk, arst_n, cmd_valid && cmd_ready && (pend_q == 4'd0), !res_valid, "result too early")

	// Configuration inputs are visible here but carry no timing rule
	logic unused_cfg;
	assign unused_cfg = wr_en ^ wr_data;

endmodule

bind rgb_color_matrix_gamma rcmg_checker u_rcmg_checker (.*);
